// ===== rtl/core/iem_pkg.sv =====
package iem_pkg;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_SUPPLY = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NACK  = 2'd2;

  localparam logic [7:0] CFG_DEVICE_ADDRESS    = 8'd0;
  localparam logic [7:0] CFG_PAGE_COUNT        = 8'd1;
  localparam logic [7:0] CFG_ACK_RETRY_LIMIT   = 8'd2;
  localparam logic [7:0] CFG_WRITE_WAIT_PHASES = 8'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic        is_read;
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       need_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  reg_index;
    logic [19:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [7:0]  ack_retry_limit;
    logic [19:0] write_wait_phases;
    logic [19:0] address_limit;
  } seq_cfg_t;

endpackage

// ===== rtl/core/iem_in_if.sv =====
interface iem_in_if;
  logic               valid;
  logic               ready;
  iem_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/iem_out_if.sv =====
interface iem_out_if;
  logic               valid;
  logic               ready;
  iem_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/iem_cfg_if.sv =====
interface iem_cfg_if;
  logic               valid;
  logic               ready;
  iem_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/iem_seq.sv =====
module iem_seq #(
  parameter int PAGE_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  iem_pkg::in_item_t  item,
  input  iem_pkg::seq_cfg_t  cfg,
  output iem_pkg::out_item_t res
);

  typedef enum logic [4:0] {
    S_IDLE, S_START_W, S_DEV_W, S_DEV_W_ACK, S_ADDR, S_ADDR_ACK, S_DATA,
    S_DATA_ACK, S_STOP_PAGE, S_WAIT, S_START_R, S_DEV_R, S_DEV_R_ACK,
    S_RECV, S_MACK, S_STOP_END, S_STOP_FAIL
  } state_t;

  typedef enum logic [2:0] {
    K_IDLE, K_START, K_SEND, K_ACK, K_RECV, K_MACK, K_STOP, K_WAIT
  } kind_t;

  localparam logic [8:0]  PAGE_U = 9'(PAGE_BYTES);
  localparam logic [23:0] RECIP  = 24'((1 << 24) / PAGE_BYTES);

  function automatic kind_t kind_of(state_t s);
    kind_t k;
    case (s)
      S_START_W, S_START_R:                          k = K_START;
      S_DEV_W, S_ADDR, S_DATA, S_DEV_R:              k = K_SEND;
      S_DEV_W_ACK, S_ADDR_ACK, S_DATA_ACK, S_DEV_R_ACK: k = K_ACK;
      S_RECV:                                        k = K_RECV;
      S_MACK:                                        k = K_MACK;
      S_STOP_PAGE, S_STOP_END, S_STOP_FAIL:          k = K_STOP;
      S_WAIT:                                        k = K_WAIT;
      default:                                       k = K_IDLE;
    endcase
    return k;
  endfunction

  state_t      state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [8:0]  page_left_r, page_left_nxt;
  logic [7:0]  tries_r, tries_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic        read_mode_r, read_mode_nxt;
  logic        held_r, held_nxt;

  // start-address remainder by page size, in two stages after a write begin: prod_r, then page_left_r
  logic        rem_v_r;
  logic [39:0] prod_r;
  logic        rem_go;
  logic [15:0] rem_q;
  logic [24:0] rem_qp;
  logic [24:0] rem_full;
  logic [9:0]  rem_est;
  logic [9:0]  rem_fix;
  logic [8:0]  rem_room;
  logic [8:0]  rem_page;

  logic        fin, eoi, apw, rvalid, scl, sda, need;
  logic [1:0]  fin_st;
  logic [7:0]  rbyte, recv_byte;
  logic [15:0] left_dec;
  logic [8:0]  page_dec;
  kind_t       k_cur, k_nxt;

  always_comb begin
    rem_q    = prod_r[39:24];
    rem_qp   = {9'd0, rem_q} * {16'd0, PAGE_U};
    rem_full = {9'd0, addr_r} - rem_qp;
    rem_est  = rem_full[9:0];
    rem_fix  = (rem_est >= {1'b0, PAGE_U}) ? rem_est - {1'b0, PAGE_U} : rem_est;
    rem_room = PAGE_U - rem_fix[8:0];
    rem_page = (left_r < {7'd0, rem_room}) ? left_r[8:0] : rem_room;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    addr_nxt      = addr_r;
    left_nxt      = left_r;
    page_left_nxt = rem_v_r ? rem_page : page_left_r;
    tries_nxt     = tries_r;
    wait_nxt      = wait_r;
    read_mode_nxt = read_mode_r;
    held_nxt      = held_r;
    fin           = 1'b0;
    fin_st        = iem_pkg::ST_OK;
    eoi           = 1'b0;
    apw           = 1'b0;
    rvalid        = 1'b0;
    rbyte         = 8'd0;
    rem_go        = 1'b0;
    recv_byte     = {shift_r[6:0], item.sda_in};
    left_dec      = left_r - 16'd1;
    page_dec      = page_left_r - 9'd1;
    k_cur         = kind_of(state_r);

    if (accept) begin
      unique case (item.action)
        iem_pkg::ACT_BEGIN: begin
          if (state_r == S_IDLE) begin
            read_mode_nxt = item.is_read;
            tries_nxt     = 8'd0;
            held_nxt      = 1'b0;
            if ({4'd0, item.start_address} >= cfg.address_limit) begin
              fin    = 1'b1;
              fin_st = iem_pkg::ST_RANGE;
            end else if (item.byte_count == 16'd0) begin
              fin = 1'b1;
            end else begin
              addr_nxt  = item.start_address;
              left_nxt  = item.byte_count;
              state_nxt = S_START_W;
              phase_nxt = 2'd0;
              bit_nxt   = 3'd0;
              if (item.is_read) begin
                page_left_nxt = 9'd0;
              end else begin
                rem_go = 1'b1;
              end
            end
          end
        end
        iem_pkg::ACT_SUPPLY: begin
          if (state_r == S_DATA && !held_r) begin
            shift_nxt = item.write_byte;
            held_nxt  = 1'b1;
            phase_nxt = 2'd0;
            bit_nxt   = 3'd0;
          end
        end
        iem_pkg::ACT_TICK: begin
          unique case (k_cur)
            K_START, K_STOP, K_MACK: begin
              if (phase_r != 2'd3) phase_nxt = phase_r + 2'd1;
              else begin
                phase_nxt = 2'd0;
                eoi       = 1'b1;
              end
            end
            K_SEND: begin
              if (!(state_r == S_DATA && !held_r)) begin
                if (phase_r != 2'd3) phase_nxt = phase_r + 2'd1;
                else begin
                  phase_nxt = 2'd0;
                  if (bit_r != 3'd7) bit_nxt = bit_r + 3'd1;
                  else begin
                    bit_nxt   = 3'd0;
                    state_nxt = state_t'(state_r + 5'd1);
                    tries_nxt = 8'd0;
                  end
                end
              end
            end
            K_ACK: begin
              if (phase_r != 2'd3) phase_nxt = phase_r + 2'd1;
              else if (!item.sda_in) begin
                tries_nxt = 8'd0;
                phase_nxt = 2'd0;
                eoi       = 1'b1;
              end else if (tries_r >= cfg.ack_retry_limit) begin
                tries_nxt = 8'd0;
                phase_nxt = 2'd0;
                state_nxt = S_STOP_FAIL;
              end else begin
                tries_nxt = tries_r + 8'd1;
              end
            end
            K_RECV: begin
              if (phase_r != 2'd3) phase_nxt = phase_r + 2'd1;
              else begin
                shift_nxt = recv_byte;
                phase_nxt = 2'd0;
                if (bit_r != 3'd7) bit_nxt = bit_r + 3'd1;
                else begin
                  bit_nxt   = 3'd0;
                  rvalid    = 1'b1;
                  rbyte     = recv_byte;
                  state_nxt = S_MACK;
                end
              end
            end
            K_WAIT: begin
              if (wait_r > 20'd1) wait_nxt = wait_r - 20'd1;
              else begin
                wait_nxt = 20'd0;
                apw      = 1'b1;
              end
            end
            K_IDLE: state_nxt = S_IDLE;
          endcase
        end
        default: ;
      endcase
    end

    if (eoi) begin
      case (state_r)
        S_START_W: begin
          state_nxt = S_DEV_W;
          shift_nxt = cfg.device_address | {addr_r[14:8], 1'b0};
        end
        S_DEV_W_ACK: begin
          state_nxt = S_ADDR;
          shift_nxt = addr_r[7:0];
        end
        S_ADDR_ACK: begin
          if (read_mode_r) state_nxt = S_START_R;
          else begin
            state_nxt = S_DATA;
            held_nxt  = 1'b0;
          end
        end
        S_DATA_ACK: begin
          addr_nxt      = addr_r + 16'd1;
          left_nxt      = left_dec;
          page_left_nxt = page_dec;
          held_nxt      = 1'b0;
          state_nxt     = (page_dec == 9'd0 || left_dec == 16'd0) ? S_STOP_PAGE : S_DATA;
        end
        S_START_R: begin
          state_nxt = S_DEV_R;
          shift_nxt = cfg.device_address | {addr_r[14:8], 1'b1};
        end
        S_DEV_R_ACK: begin
          state_nxt = S_RECV;
          shift_nxt = 8'd0;
        end
        S_MACK: begin
          addr_nxt  = addr_r + 16'd1;
          left_nxt  = left_dec;
          state_nxt = (left_dec == 16'd0) ? S_STOP_END : S_RECV;
          shift_nxt = 8'd0;
        end
        S_STOP_PAGE: begin
          if (cfg.write_wait_phases == 20'd0) apw = 1'b1;
          else begin
            wait_nxt  = cfg.write_wait_phases;
            state_nxt = S_WAIT;
          end
        end
        S_STOP_END: fin = 1'b1;
        S_STOP_FAIL: begin
          fin    = 1'b1;
          fin_st = iem_pkg::ST_NACK;
        end
        default: state_nxt = S_IDLE;
      endcase
    end

    if (apw) begin
      if (left_r == 16'd0) fin = 1'b1;
      else begin
        page_left_nxt = (left_r < {7'd0, PAGE_U}) ? left_r[8:0] : PAGE_U;
        state_nxt     = S_START_W;
        phase_nxt     = 2'd0;
        bit_nxt       = 3'd0;
      end
    end

    if (fin) begin
      state_nxt = S_IDLE;
      phase_nxt = 2'd0;
      bit_nxt   = 3'd0;
      held_nxt  = 1'b0;
      tries_nxt = 8'd0;
    end
  end

  // bus drive for the phase the sequencer moves into
  always_comb begin
    k_nxt = kind_of(state_nxt);
    scl   = 1'b1;
    sda   = 1'b1;
    need  = 1'b0;
    unique case (k_nxt)
      K_START: begin
        scl = (phase_nxt == 2'd1 || phase_nxt == 2'd2);
        sda = (phase_nxt <= 2'd1);
      end
      K_SEND: begin
        if (state_nxt == S_DATA && !held_nxt) begin
          scl  = 1'b0;
          need = 1'b1;
        end else begin
          scl = (phase_nxt >= 2'd2);
          sda = shift_nxt[~bit_nxt];
        end
      end
      K_ACK, K_RECV: scl = (phase_nxt >= 2'd2);
      K_MACK: begin
        scl = (phase_nxt >= 2'd2);
        sda = (left_nxt <= 16'd1);
      end
      K_STOP: begin
        scl = (phase_nxt >= 2'd1);
        sda = (phase_nxt >= 2'd2);
      end
      K_WAIT, K_IDLE: ;
    endcase

    res.scl_out    = scl;
    res.sda_out    = sda;
    res.need_byte  = need;
    res.read_byte  = rbyte;
    res.read_valid = rvalid;
    res.busy_res   = (state_nxt != S_IDLE);
    res.done_res   = fin;
    res.status     = fin_st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 2'd0;
      bit_r       <= 3'd0;
      shift_r     <= 8'd0;
      addr_r      <= 16'd0;
      left_r      <= 16'd0;
      page_left_r <= 9'd0;
      tries_r     <= 8'd0;
      wait_r      <= 20'd0;
      read_mode_r <= 1'b0;
      held_r      <= 1'b0;
      rem_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      addr_r      <= addr_nxt;
      left_r      <= left_nxt;
      page_left_r <= page_left_nxt;
      tries_r     <= tries_nxt;
      wait_r      <= wait_nxt;
      read_mode_r <= read_mode_nxt;
      held_r      <= held_nxt;
      rem_v_r     <= rem_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rem_go) prod_r <= {24'd0, item.start_address} * {16'd0, RECIP};
  end

endmodule

// ===== rtl/core/i2c_eeprom_master_core.sv =====
// Each accepted input beat's result beat is registered and offered in the following cycle.
// Throughput: one item per cycle while the result sink keeps up; the bus sequencer steps once per beat.
// Input ready drops only while a result beat waits and the sink stalls.
// Reset (rst_n, synchronous, active low): sequencer idle, bus released,
// configuration at defaults; no clearing pass.
module i2c_eeprom_master_core #(
  parameter int PAGE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  iem_in_if.sink      in_bus,
  iem_out_if.source   out_bus,
  iem_cfg_if.sink     cfg_bus
);

  logic [7:0]  dev_addr_r;
  logic [7:0]  retry_r;
  logic [19:0] wait_phases_r;
  logic [19:0] limit_r;

  logic               out_valid_r;
  iem_pkg::out_item_t out_data_r;
  iem_pkg::out_item_t res;
  iem_pkg::seq_cfg_t  seq_cfg;
  logic               in_accept;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_accept     = in_bus.valid && in_bus.ready;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  assign seq_cfg.device_address    = dev_addr_r;
  assign seq_cfg.ack_retry_limit   = retry_r;
  assign seq_cfg.write_wait_phases = wait_phases_r;
  assign seq_cfg.address_limit     = limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= 8'd160;
      retry_r       <= 8'd10;
      wait_phases_r <= 20'd1333;
      limit_r       <= 20'(128 * PAGE_BYTES);
    end else if (cfg_bus.valid) begin
      case (cfg_bus.data.reg_index)
        iem_pkg::CFG_DEVICE_ADDRESS:    dev_addr_r <= cfg_bus.data.wdata[7:0];
        iem_pkg::CFG_PAGE_COUNT:
          limit_r <= {8'd0, cfg_bus.data.wdata[11:0]} * 20'(PAGE_BYTES);
        iem_pkg::CFG_ACK_RETRY_LIMIT:   retry_r <= cfg_bus.data.wdata[7:0];
        iem_pkg::CFG_WRITE_WAIT_PHASES: wait_phases_r <= cfg_bus.data.wdata;
        default: ;
      endcase
    end
  end

  iem_seq #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_bus.data),
    .cfg    (seq_cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= res;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done beat reports busy");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != iem_pkg::ST_OK |-> out_data_r.done_res)
    else $error("error status without done");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.read_valid |-> out_data_r.busy_res && !out_data_r.done_res)
    else $error("read byte outside a transfer");

  a_need_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.need_byte |-> !out_data_r.scl_out && out_data_r.sda_out)
    else $error("bus not held while waiting for write data");

endmodule
